// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the deframer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wsd_pkg.sv -----
// shared types and constants for the websocket frame deframer
// no dependencies
package wsd_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] op_tag;
        logic       is_control;
        logic       last;
        logic [2:0] error_code;
    } t_result;

    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_EMPTY_END = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UNMASKED = 3'd1;
    localparam logic [2:0] ERR_BAD_CTRL = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd3;
    localparam logic [2:0] ERR_ORPHAN   = 3'd4;

    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam logic [6:0]  LEN16_CODE   = 7'd126;
    localparam logic [6:0]  LEN64_CODE   = 7'd127;
    localparam logic [63:0] MAX_CTRL_LEN = 64'd125;

    function automatic logic is_ctrl_op(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

// ----- hw/rtl/wsd_front.sv -----
// header parser and unmasker: takes one stream byte a cycle while i_ready is high, emits at most one result
// depends on wsd_pkg
module wsd_front import wsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_ready,
    output logic       o_ready,
    output logic       o_valid,
    output t_result    o_result,
    output logic       o_err
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic [2:0]  r_ext_cnt, n_ext_cnt;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_mask, n_mask;
    logic [1:0]  r_mask_idx, n_mask_idx;
    logic [3:0]  r_open_op, n_open_op;
    logic        r_have_open, n_have_open;
    logic        r_err, n_err;

    logic        accept;
    logic        emit;
    logic        check;
    logic        ctrl;
    logic        body_end;
    logic [2:0]  err_code;
    logic [7:0]  mask_byte;
    t_result     res;

    assign accept  = i_valid && i_ready;
    assign o_ready = i_ready;
    assign o_valid = accept && emit;
    assign o_result = res;
    assign o_err   = r_err;

    assign ctrl     = is_ctrl_op(r_opcode);
    assign body_end = (r_rem == 64'd1);

    always_comb begin
        case (r_mask_idx)
            2'd0:    mask_byte = r_mask[31:24];
            2'd1:    mask_byte = r_mask[23:16];
            2'd2:    mask_byte = r_mask[15:8];
            default: mask_byte = r_mask[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_ext_cnt   = r_ext_cnt;
        n_rem       = r_rem;
        n_mask      = r_mask;
        n_mask_idx  = r_mask_idx;
        n_open_op   = r_open_op;
        n_have_open = r_have_open;
        n_err       = r_err;
        emit        = 1'b0;
        check       = 1'b0;
        err_code    = ERR_NONE;
        res         = '0;

        if (!r_err) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    if (!i_byte[7]) begin
                        err_code = ERR_UNMASKED;
                    end else if (i_byte[6:0] == LEN16_CODE) begin
                        n_rem     = '0;
                        n_ext_cnt = 3'd1;
                        n_phase   = PH_EXT;
                    end else if (i_byte[6:0] == LEN64_CODE) begin
                        n_rem     = '0;
                        n_ext_cnt = 3'd7;
                        n_phase   = PH_EXT;
                    end else begin
                        n_rem = {57'd0, i_byte[6:0]};
                        check = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_rem = {r_rem[55:0], i_byte};
                    if (r_ext_cnt == 3'd0) begin
                        check = 1'b1;
                    end else begin
                        n_ext_cnt = r_ext_cnt - 3'd1;
                    end
                end
                PH_MASK: begin
                    n_mask = {r_mask[23:0], i_byte};
                    if (r_mask_idx != 2'd3) begin
                        n_mask_idx = r_mask_idx + 2'd1;
                    end else begin
                        n_mask_idx = 2'd0;
                        if (r_rem != 64'd0) begin
                            n_phase = PH_BODY;
                        end else begin
                            n_phase = PH_HDR0;
                            if (ctrl) begin
                                emit           = 1'b1;
                                res.kind       = KIND_EMPTY_END;
                                res.op_tag     = r_opcode;
                                res.is_control = 1'b1;
                                res.last       = 1'b1;
                            end else if (r_fin) begin
                                emit           = 1'b1;
                                res.kind       = KIND_EMPTY_END;
                                res.op_tag     = r_open_op;
                                res.last       = 1'b1;
                                n_have_open    = 1'b0;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    n_mask_idx     = r_mask_idx + 2'd1;
                    n_rem          = r_rem - 64'd1;
                    emit           = 1'b1;
                    res.kind       = KIND_PAYLOAD;
                    res.data       = i_byte ^ mask_byte;
                    res.op_tag     = ctrl ? r_opcode : r_open_op;
                    res.is_control = ctrl;
                    res.last       = body_end && (ctrl || r_fin);
                    if (body_end) begin
                        n_phase = PH_HDR0;
                        if (!ctrl && r_fin) begin
                            n_have_open = 1'b0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase
        end

        // frame checks once the length is known
        if (check) begin
            if (ctrl) begin
                if ((n_rem > MAX_CTRL_LEN) || !r_fin) begin
                    err_code = ERR_BAD_CTRL;
                end
            end else if ((r_opcode == OP_TEXT) || (r_opcode == OP_BINARY)) begin
                n_open_op   = r_opcode;
                n_have_open = 1'b1;
            end else if (r_opcode == OP_CONT) begin
                if (!r_have_open) begin
                    err_code = ERR_ORPHAN;
                end
            end else begin
                err_code = ERR_UNKNOWN;
            end
            if (err_code == ERR_NONE) begin
                n_phase    = PH_MASK;
                n_mask_idx = 2'd0;
            end
        end

        if (err_code != ERR_NONE) begin
            n_err          = 1'b1;
            emit           = 1'b1;
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = err_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_fin       <= 1'b0;
            r_opcode    <= 4'd0;
            r_ext_cnt   <= 3'd0;
            r_rem       <= 64'd0;
            r_mask      <= 32'd0;
            r_mask_idx  <= 2'd0;
            r_open_op   <= 4'd0;
            r_have_open <= 1'b0;
            r_err       <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_ext_cnt   <= n_ext_cnt;
            r_rem       <= n_rem;
            r_mask      <= n_mask;
            r_mask_idx  <= n_mask_idx;
            r_open_op   <= n_open_op;
            r_have_open <= n_have_open;
            r_err       <= n_err;
        end
    end

endmodule

// ----- hw/rtl/wsd_queue.sv -----
// short result queue between the parser and the output stage
// depends on wsd_pkg
module wsd_queue import wsd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_item,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_item,
    input  logic    i_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            push, pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/wsd_back.sv -----
// output register stage: pulls results from the queue and holds them for the sink
// depends on wsd_pkg
module wsd_back import wsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_item,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_item,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

endmodule

// ----- hw/rtl/websocket_frame_deframer_top.sv -----
// top level of the websocket client frame deframer
// depends on wsd_pkg, wsd_front, wsd_queue, wsd_back and assert_macros.svh
//
// Receives a client-to-server WebSocket byte stream, one byte per word, and
// returns unmasked payload bytes tagged with the message or control opcode,
// empty-end words for zero-length endings and a single error word on the
// first bad frame, after which all input is swallowed until reset. Input is
// taken at one byte per clock while the queue has room: the header parser
// updates its state and unmasks in the cycle a byte is accepted, so a new
// byte can follow every cycle. A result passes through the queue and then
// the output register: the queue is written at the edge that accepts its
// byte, and the output register loads it from the queue when it has room.
// The queue holds QUEUE_DEPTH words and the output register one more, so
// the input keeps flowing for QUEUE_DEPTH + 1 results while the sink
// stalls; every byte, even one that gives no result (header, length, mask),
// is taken only while the queue has room.
`include "assert_macros.svh"

module websocket_frame_deframer_top import wsd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte[7:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // data[7:0], op_tag[11:8], error_code[14:12], pad
    output logic [2:0]  o_m_axis_tuser,   // kind[1:0], is_control[2]
    output logic        o_m_axis_tlast
);

    logic    front_valid, front_err;
    t_result front_item;
    logic    q_ready, q_valid;
    t_result q_item;
    logic    back_ready;
    t_result out_item;

    wsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .i_ready  (q_ready),
        .o_ready  (o_s_axis_tready),
        .o_valid  (front_valid),
        .o_result (front_item),
        .o_err    (front_err)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (back_ready)
    );

    wsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_ready (back_ready),
        .o_valid (o_m_axis_tvalid),
        .o_item  (out_item),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {1'b0, out_item.error_code, out_item.op_tag, out_item.data};
    assign o_m_axis_tuser = {out_item.is_control, out_item.kind};
    assign o_m_axis_tlast = out_item.last;

    `WSD_ASSERT_IMPL(a_silent_after_error, i_clk, i_rst_n, front_err, !front_valid, "result after error")
    `WSD_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, front_err, front_err, "error flag cleared")
    `WSD_ASSERT_IMPL(a_error_word_code, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser[1:0] == KIND_ERROR), o_m_axis_tdata[14:12] != ERR_NONE, "error word without code")

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for websocket_frame_deframer_top
// depends on wsd_pkg and the deframer rtl; needs no other file
`timescale 1ns / 1ps

module tb_top;
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_B0,
        AWAIT_B1,
        EXT_LEN,
        MASK_KEY,
        PAYLOAD
    } rx_phase_e;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    want;
    } stim_row_t;

    localparam t_result NO_WORD = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata = 8'h00;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // typed expectation riding along with the byte on the bus
    logic    word_typed = 1'b0;
    t_result word_want = '0;

    t_result     words_due[$];
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    bit          gen_open = 1'b0;

    int unsigned src_run = 0;
    bit          src_calm = 1'b0;
    int unsigned sink_run = 0;
    bit          sink_calm = 1'b0;
    int unsigned sink_hold = 0;

    rx_phase_e   rx_phase = AWAIT_B0;
    logic        rx_fin = 1'b0;
    logic [3:0]  rx_op = OP_CONT;
    logic [2:0]  rx_ext_left = '0;
    logic [63:0] rx_len_left = '0;
    logic [31:0] rx_key = '0;
    logic [1:0]  rx_key_pos = '0;
    logic [3:0]  rx_msg_op = OP_CONT;
    logic        rx_msg_open = 1'b0;
    logic        rx_halted = 1'b0;

    bit          pred_got;
    t_result     pred_word;
    t_result     due_word;

    stim_row_t directed_rows [28] = '{
        // empty ping, reserved bits set
        '{8'hF9, 1'b0, NO_WORD}, '{8'h80, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b1, '{KIND_EMPTY_END, 8'h00, OP_PING, 1'b1, 1'b1, ERR_NONE}},
        // one byte binary, 16-bit length, zero key
        '{8'h82, 1'b0, NO_WORD}, '{8'hFE, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h01, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, OP_BINARY, 1'b0, 1'b1, ERR_NONE}},
        // text fragment, all-ones key
        '{8'h01, 1'b0, NO_WORD}, '{8'h81, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
        '{8'h00, 1'b1, '{KIND_PAYLOAD, 8'hFF, OP_TEXT, 1'b0, 1'b0, ERR_NONE}},
        // empty final continuation closes the text message
        '{8'h80, 1'b0, NO_WORD}, '{8'h80, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b1, '{KIND_EMPTY_END, 8'h00, OP_TEXT, 1'b0, 1'b1, ERR_NONE}}
    };

    websocket_frame_deframer_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned draw_wait(inout int unsigned run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(16, 96);
            calm = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic bit control_op(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

    task automatic deframe_byte(input logic [7:0] b, output bit got, output t_result w);
        logic [2:0] err;
        bit         len_done;
        bit         ctl;
        bit         frame_end;
        logic [7:0] key_byte;
        got = 1'b0;
        w = '0;
        err = ERR_NONE;
        len_done = 1'b0;
        if (rx_halted) return;
        case (rx_phase)
            AWAIT_B0: begin
                rx_fin = b[7];
                rx_op = b[3:0];
                rx_phase = AWAIT_B1;
            end
            AWAIT_B1: begin
                if (!b[7]) begin
                    err = ERR_UNMASKED;
                end else begin
                    rx_len_left = '0;
                    if (b[6:0] == LEN16_CODE) begin
                        rx_ext_left = 3'd1;
                        rx_phase = EXT_LEN;
                    end else if (b[6:0] == LEN64_CODE) begin
                        rx_ext_left = 3'd7;
                        rx_phase = EXT_LEN;
                    end else begin
                        rx_len_left = 64'(b[6:0]);
                        len_done = 1'b1;
                    end
                end
            end
            EXT_LEN: begin
                rx_len_left = {rx_len_left[55:0], b};
                if (rx_ext_left == 0) len_done = 1'b1;
                else rx_ext_left--;
            end
            MASK_KEY: begin
                rx_key = {rx_key[23:0], b};
                if (rx_key_pos != 2'd3) begin
                    rx_key_pos++;
                end else begin
                    rx_key_pos = '0;
                    if (rx_len_left != 0) begin
                        rx_phase = PAYLOAD;
                    end else begin
                        rx_phase = AWAIT_B0;
                        if (control_op(rx_op)) begin
                            got = 1'b1;
                            w = '{KIND_EMPTY_END, 8'h00, rx_op, 1'b1, 1'b1, ERR_NONE};
                        end else if (rx_fin) begin
                            got = 1'b1;
                            w = '{KIND_EMPTY_END, 8'h00, rx_msg_op, 1'b0, 1'b1, ERR_NONE};
                            rx_msg_open = 1'b0;
                        end
                    end
                end
            end
            PAYLOAD: begin
                key_byte = rx_key[8 * (3 - rx_key_pos) +: 8];
                rx_key_pos++;
                rx_len_left--;
                frame_end = (rx_len_left == 0);
                ctl = control_op(rx_op);
                got = 1'b1;
                w = '{KIND_PAYLOAD, b ^ key_byte, ctl ? rx_op : rx_msg_op, ctl,
                      frame_end && (ctl || rx_fin), ERR_NONE};
                if (frame_end) begin
                    rx_phase = AWAIT_B0;
                    if (!ctl && rx_fin) rx_msg_open = 1'b0;
                end
            end
            default: rx_phase = AWAIT_B0;
        endcase
        if (len_done) begin
            if (control_op(rx_op)) begin
                if (rx_len_left > MAX_CTRL_LEN || !rx_fin) err = ERR_BAD_CTRL;
            end else if (rx_op == OP_TEXT || rx_op == OP_BINARY) begin
                rx_msg_op = rx_op;
                rx_msg_open = 1'b1;
            end else if (rx_op == OP_CONT) begin
                if (!rx_msg_open) err = ERR_ORPHAN;
            end else begin
                err = ERR_UNKNOWN;
            end
            if (err == ERR_NONE) begin
                rx_phase = MASK_KEY;
                rx_key_pos = '0;
            end
        end
        if (err != ERR_NONE) begin
            rx_halted = 1'b1;
            got = 1'b1;
            w = '{KIND_ERROR, 8'h00, 4'h0, 1'b0, 1'b0, err};
        end
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                deframe_byte(i_s_axis_tdata, pred_got, pred_word);
                if (word_typed) words_due.push_back(word_want);
                else if (pred_got) words_due.push_back(pred_word);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (words_due.size() == 0) begin
                    $error("unexpected word: tdata %h tuser %h tlast %b",
                           o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    mismatches++;
                end else begin
                    due_word = words_due.pop_front();
                    check_field("kind", due_word.kind, o_m_axis_tuser[1:0]);
                    check_field("data", due_word.data, o_m_axis_tdata[7:0]);
                    check_field("op_tag", due_word.op_tag, o_m_axis_tdata[11:8]);
                    check_field("is_control", due_word.is_control, o_m_axis_tuser[2]);
                    check_field("last", due_word.last, o_m_axis_tlast);
                    check_field("error_code", due_word.error_code, o_m_axis_tdata[14:12]);
                end
            end
        end
    end

    // sink side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) sink_hold = draw_wait(sink_run, sink_calm);
            else if (sink_hold > 0) sink_hold--;
            i_m_axis_tready <= (sink_hold == 0);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic typed, input t_result want);
        int unsigned gap;
        gap = draw_wait(src_run, src_calm);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        word_typed <= typed;
        word_want <= want;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input int unsigned len);
        int unsigned code_sel;
        logic [63:0] len64;
        logic [31:0] key;
        code_sel = $urandom_range(0, 9);
        len64 = 64'(len);
        key = $urandom;
        send_byte({fin, 3'($urandom_range(0, 7)), op}, 1'b0, NO_WORD);
        if (code_sel == 1) begin
            send_byte({1'b1, LEN64_CODE}, 1'b0, NO_WORD);
            for (int i = 7; i >= 0; i--) send_byte(len64[8 * i +: 8], 1'b0, NO_WORD);
        end else if (len > 125 || code_sel == 0) begin
            send_byte({1'b1, LEN16_CODE}, 1'b0, NO_WORD);
            send_byte(len64[15:8], 1'b0, NO_WORD);
            send_byte(len64[7:0], 1'b0, NO_WORD);
        end else begin
            send_byte({1'b1, len64[6:0]}, 1'b0, NO_WORD);
        end
        for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8], 1'b0, NO_WORD);
        repeat (len) send_byte(8'($urandom), 1'b0, NO_WORD);
    endtask

    // one bad frame ends the run, then bytes that must be swallowed
    task automatic send_fault();
        logic [2:0] pick;
        logic [3:0] op;
        pick = 3'($urandom_range(ERR_UNMASKED, ERR_ORPHAN));
        case (pick)
            ERR_UNMASKED: begin
                send_byte({1'b1, 3'b000, OP_BINARY}, 1'b0, NO_WORD);
                send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b1,
                          '{KIND_ERROR, 8'h00, 4'h0, 1'b0, 1'b0, ERR_UNMASKED});
            end
            ERR_BAD_CTRL: begin
                if ($urandom_range(0, 1) == 0) begin
                    send_byte({1'b0, 3'b000, OP_PING}, 1'b0, NO_WORD);
                    send_byte(8'h80, 1'b1,
                              '{KIND_ERROR, 8'h00, 4'h0, 1'b0, 1'b0, ERR_BAD_CTRL});
                end else begin
                    send_byte({1'b1, 3'b000, OP_CLOSE}, 1'b0, NO_WORD);
                    send_byte({1'b1, LEN16_CODE}, 1'b0, NO_WORD);
                    send_byte(8'h00, 1'b0, NO_WORD);
                    send_byte(8'd126, 1'b1,
                              '{KIND_ERROR, 8'h00, 4'h0, 1'b0, 1'b0, ERR_BAD_CTRL});
                end
            end
            ERR_UNKNOWN: begin
                op = 4'($urandom_range(3, 7) + ($urandom_range(0, 1) ? 8 : 0));
                send_byte({1'b1, 3'b000, op}, 1'b0, NO_WORD);
                send_byte(8'h80, 1'b1,
                          '{KIND_ERROR, 8'h00, 4'h0, 1'b0, 1'b0, ERR_UNKNOWN});
            end
            default: begin
                if (gen_open) send_frame(1'b1, OP_CONT, 0);
                gen_open = 1'b0;
                send_byte({1'b1, 3'b000, OP_CONT}, 1'b0, NO_WORD);
                send_byte(8'h83, 1'b1,
                          '{KIND_ERROR, 8'h00, 4'h0, 1'b0, 1'b0, ERR_ORPHAN});
            end
        endcase
        repeat (24) send_byte(8'($urandom), 1'b0, NO_WORD);
    endtask

    initial begin
        int unsigned r;
        int unsigned len;
        int unsigned len_sel;
        logic [3:0]  op;
        logic        fin;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        while (bytes_sent < 1150) begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                case ($urandom_range(0, 2))
                    0: op = OP_CLOSE;
                    1: op = OP_PING;
                    default: op = OP_PONG;
                endcase
                fin = 1'b1;
            end else if (gen_open && r < 60) begin
                op = OP_CONT;
                fin = 1'($urandom_range(0, 1));
                if (fin) gen_open = 1'b0;
            end else begin
                op = ($urandom_range(0, 1) == 0) ? OP_TEXT : OP_BINARY;
                fin = 1'($urandom_range(0, 1));
                gen_open = !fin;
            end
            len_sel = $urandom_range(0, 31);
            if (len_sel == 0) len = control_op(op) ? 125 : $urandom_range(126, 400);
            else if (len_sel < 4) len = $urandom_range(0, 125);
            else len = $urandom_range(0, 6);
            send_frame(fin, op, len);
        end
        send_fault();
        i_s_axis_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_queue.sv
hw/rtl/wsd_back.sv
hw/rtl/websocket_frame_deframer_top.sv
dv/tb_top.sv
